// ===== rtl/core/ftda_pkg.sv =====
// Shared types, constants and helpers for the float to decimal ASCII printer.
package ftda_pkg;

    localparam int MAX_LENGTH_DEF    = 17;
    localparam int MAX_PRECISION_DEF = 7;
    localparam int NUM_W             = 62;
    localparam int DIG_W             = 4;
    localparam int MAX_DIGITS        = 19;
    localparam int DIG_CNT_W         = 5;
    localparam int POS_W             = 6;

    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_POINT = 7'h2e;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SHIFT,
        S_DIGIT,
        S_CHECK,
        S_EMIT,
        S_OVF
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic shift;
        logic digit;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic       special;
        logic       dig_done;
        logic       too_long;
        logic       emit_last;
    } t_status;

    function automatic logic [29:0] pow10(input logic [3:0] p);
        logic [29:0] r;
        begin
            case (p)
                4'd0:    r = 30'd1;
                4'd1:    r = 30'd10;
                4'd2:    r = 30'd100;
                4'd3:    r = 30'd1000;
                4'd4:    r = 30'd10000;
                4'd5:    r = 30'd100000;
                4'd6:    r = 30'd1000000;
                4'd7:    r = 30'd10000000;
                4'd8:    r = 30'd100000000;
                default: r = 30'd1000000000;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/float_to_decimal_ascii_core.sv =====
// Top level of the single-precision to fixed-precision decimal ASCII printer.
// Input channel s_axis: tdata[31:0] = value_bits, tdata[34:32] = precision.
// Output channel m_axis: tdata[6:0] = out_char, tlast = last_char,
// tuser = overflow.
// One item at a time: after acceptance the controller loads the operands,
// multiplies the mantissa by 10^p, applies the rounding shift and then
// peels one decimal digit at a time with an iterative divide-by-ten unit.
// The scaled value has at least p + 1 and at most 17 decimal digits.
// Characters then leave one per cycle while m_axis_tready is high;
// a stall holds the current character and tlast in place.
// A new item is taken only after the last character of the previous one
// has been accepted. NaN, infinity, |x| >= 2^31 or an over-long text give
// one character 0 with tuser set.
// Synchronous active-low reset returns the controller to idle.
module float_to_decimal_ascii_core #(
    parameter int MAX_LENGTH    = ftda_pkg::MAX_LENGTH_DEF,
    parameter int MAX_PRECISION = ftda_pkg::MAX_PRECISION_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value_bits[31:0], precision[34:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_char[6:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // overflow
);
    import ftda_pkg::*;

    t_cmd       cmd;
    t_status    status;
    logic [6:0] dp_char;
    logic       ovf;

    ftda_datapath #(.MAX_LENGTH(MAX_LENGTH), .MAX_PRECISION(MAX_PRECISION)) u_dp (
        .i_clk        (i_clk),
        .i_value_bits (s_axis_tdata[31:0]),
        .i_precision  (s_axis_tdata[34:32]),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_char       (dp_char)
    );

    ftda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_out_valid (m_axis_tvalid),
        .o_last      (m_axis_tlast),
        .o_ovf       (ovf),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tuser = ovf;
    assign m_axis_tdata = {1'b0, ovf ? 7'd0 : dp_char};

endmodule

// ===== rtl/core/ftda_datapath.sv =====
// Datapath: scaling multiply, rounding shift, digit extraction and character output.
module ftda_datapath #(
    parameter int MAX_LENGTH    = ftda_pkg::MAX_LENGTH_DEF,
    parameter int MAX_PRECISION = ftda_pkg::MAX_PRECISION_DEF
) (
    input  logic              i_clk,
    input  logic [31:0]       i_value_bits,
    input  logic [2:0]        i_precision,
    input  ftda_pkg::t_cmd    i_cmd,
    output ftda_pkg::t_status o_status,
    output logic [6:0]        o_char
);
    import ftda_pkg::*;

    localparam logic [1:0] DIV_LAST = 2'd3;

    logic [7:0]           r_expf;
    logic [23:0]          r_mant;
    logic                 r_neg;
    logic [3:0]           r_prec;
    logic [NUM_W-1:0]     r_num;
    logic [DIG_W-1:0]     r_dig [MAX_DIGITS];
    logic [DIG_CNT_W-1:0] r_ndig;
    logic [DIG_CNT_W-1:0] r_nz;
    logic [POS_W-1:0]     r_pos;
    logic [1:0]           r_dstep;
    logic [NUM_W-1:0]     r_q;

    logic [3:0]           n_prec;
    logic [53:0]          n_prod;
    logic [NUM_W-1:0]     n_t;
    logic [NUM_W-1:0]     n_q;
    logic [NUM_W-1:0]     n_r;
    logic [NUM_W-1:0]     n_div;
    logic [DIG_W-1:0]     n_rem;
    logic [8:0]           sh;
    logic [NUM_W-1:0]     n_shifted;
    logic [DIG_CNT_W-1:0] n_idig;
    logic [POS_W-1:0]     n_total;
    logic [POS_W-1:0]     n_strip_len;
    logic [POS_W-1:0]     n_sign_len;
    logic [POS_W-1:0]     n_frac_start;

    always_comb begin
        if ({1'b0, i_precision} > 4'(MAX_PRECISION)) n_prec = 4'(MAX_PRECISION);
        else n_prec = {1'b0, i_precision};
    end

    assign n_prod = r_mant * pow10(r_prec);

    // Divide by ten with a reciprocal series 0.8 = 0.75 * (1 + 2^-4)(1 + 2^-8)...
    // spread over successive steps of r_dstep; the estimate is at most one low, so the last
    // step corrects it with a single compare against nine.
    always_comb begin
        n_t = '0;
        case (r_dstep)
            2'd0: begin
                n_t = (r_num >> 1) + (r_num >> 2);
                n_q = n_t + (n_t >> 4);
            end
            2'd1: begin
                n_t = r_q + (r_q >> 8);
                n_q = n_t + (n_t >> 16);
            end
            2'd2: n_q = (r_q + (r_q >> 32)) >> 3;
            default: n_q = r_q;
        endcase
        n_r = r_num - ((r_q << 3) + (r_q << 1));
        if (n_r > NUM_W'(9)) begin
            n_div = r_q + NUM_W'(1);
            n_rem = DIG_W'(n_r - NUM_W'(10));
        end else begin
            n_div = r_q;
            n_rem = DIG_W'(n_r);
        end
    end

    always_comb begin
        sh = 9'd150 - {1'b0, r_expf};
        if (r_expf == 8'd0) sh = 9'd149;
        if (r_expf > 8'd150) begin
            n_shifted = r_num << (r_expf - 8'd150);
        end else if (sh >= 9'd60) begin
            n_shifted = '0;
        end else if (sh == 9'd0) begin
            n_shifted = r_num;
        end else begin
            n_shifted = (r_num + (NUM_W'(1) << (sh - 9'd1))) >> sh;
        end
    end

    // Integer digit count: digits above the fraction, at least one.
    always_comb begin
        if (r_ndig > DIG_CNT_W'(r_prec)) n_idig = r_ndig - DIG_CNT_W'(r_prec);
        else n_idig = DIG_CNT_W'(1);
        n_sign_len = POS_W'(r_neg);
        n_total = n_sign_len + POS_W'(n_idig) + POS_W'(1) + POS_W'(r_prec);
        if (r_nz >= DIG_CNT_W'(r_prec))
            n_strip_len = n_sign_len + POS_W'(n_idig);
        else
            n_strip_len = n_total - POS_W'(r_nz);
        n_frac_start = n_sign_len + POS_W'(n_idig) + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_expf  <= i_value_bits[30:23];
            r_mant  <= {(i_value_bits[30:23] != 8'd0), i_value_bits[22:0]};
            r_neg   <= i_value_bits[31] && (i_value_bits[30:0] != 31'd0);
            r_prec  <= n_prec;
            r_ndig  <= '0;
            r_nz    <= '0;
            r_pos   <= '0;
            r_dstep <= '0;
        end
        if (i_cmd.mul) r_num <= NUM_W'(n_prod);
        if (i_cmd.shift) r_num <= n_shifted;
        if (i_cmd.digit) begin
            r_dstep <= r_dstep + 2'd1;
            if (r_dstep == DIV_LAST) begin
                for (int i = MAX_DIGITS - 1; i > 0; i--) r_dig[i] <= r_dig[i-1];
                r_dig[0] <= n_rem;
                r_num    <= n_div;
                r_ndig   <= r_ndig + DIG_CNT_W'(1);
                // Count trailing zeros of the digit string, lowest first.
                if (r_nz == r_ndig && n_rem == '0) r_nz <= r_nz + DIG_CNT_W'(1);
            end else begin
                r_q <= n_q;
            end
        end
        if (i_cmd.emit) r_pos <= r_pos + POS_W'(1);
    end

    // Digits were shifted in lowest first; the position maps to a slot counted
    // from the bottom of the padded number.
    logic [DIG_CNT_W:0]   slot;
    logic [POS_W-1:0]     dpos;
    logic [DIG_CNT_W-1:0] dig_idx;
    always_comb begin
        dpos = r_pos - n_sign_len;
        slot = '0;
        dig_idx = '0;
        o_char = CHAR_ZERO;
        if (r_neg && r_pos == '0) begin
            o_char = CHAR_MINUS;
        end else if (r_pos == n_frac_start - POS_W'(1)) begin
            o_char = CHAR_POINT;
        end else begin
            if (r_pos >= n_frac_start)
                slot = (DIG_CNT_W+1)'(r_prec) - (DIG_CNT_W+1)'(r_pos - n_frac_start) - 1'b1;
            else
                slot = (DIG_CNT_W+1)'(r_prec) + (DIG_CNT_W+1)'(n_idig)
                       - (DIG_CNT_W+1)'(dpos) - 1'b1;
            dig_idx = r_ndig - DIG_CNT_W'(1) - slot[DIG_CNT_W-1:0];
            if (slot < (DIG_CNT_W+1)'(r_ndig))
                o_char = CHAR_ZERO | {3'd0, r_dig[dig_idx]};
        end
    end

    assign o_status.special   = (r_expf >= 8'd158);
    assign o_status.dig_done  = (r_num == '0) && (r_ndig > DIG_CNT_W'(r_prec));
    assign o_status.too_long  = (n_total > POS_W'(MAX_LENGTH));
    assign o_status.emit_last = (r_pos + POS_W'(1) >= n_strip_len);

endmodule

// ===== rtl/core/ftda_ctrl.sv =====
// Controller state machine sequencing conversion and character output.
module ftda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ftda_pkg::t_status i_status,
    output ftda_pkg::t_cmd    o_cmd,
    output logic              o_out_valid,
    output logic              o_last,
    output logic              o_ovf,
    input  logic              i_out_ready
);
    import ftda_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_last      = 1'b0;
        o_ovf       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.special) n_state = S_OVF;
                else begin
                    o_cmd.mul = 1'b1;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_status.dig_done) n_state = S_CHECK;
                else o_cmd.digit = 1'b1;
            end
            S_CHECK: n_state = i_status.too_long ? S_OVF : S_EMIT;
            S_EMIT: begin
                o_out_valid = 1'b1;
                o_last = i_status.emit_last;
                if (i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) n_state = S_IDLE;
                end
            end
            S_OVF: begin
                o_out_valid = 1'b1;
                o_last = 1'b1;
                o_ovf = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/ftda_checker.sv =====
// Port-level checker for the decimal printer, bound to the top level.
module ftda_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);
    a_ovf_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'd0)
        else $error("overflow item not a lone zero");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while output pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled item changed");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not idle after last item");
endmodule

bind float_to_decimal_ascii_core ftda_checker u_chk (.*);

// ===== dv/float_to_decimal_ascii_core_tb.sv =====
// Self-checking testbench for the float to decimal ASCII printer.
module float_to_decimal_ascii_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ftda_pkg::*;

    localparam int MAXLEN  = MAX_LENGTH_DEF;
    localparam int MAXPREC = MAX_PRECISION_DEF;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [2:0]  precision;
    } t_number;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
        logic       overflow;
    } t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    t_number pending_numbers[$];
    t_char   expected_chars[$];
    int      fail_count = 0;
    int      char_count = 0;
    int      number_count = 0;
    int      overflow_count = 0;
    bit      stim_done = 1'b0;

    float_to_decimal_ascii_core u_top (.*);

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] ten_to(input int p);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < p; i++) r = r * 64'd10;
        return r;
    endfunction

    // Predicts the characters printed for one number.
    task automatic format_number(input t_number num);
        logic [7:0]  expf;
        logic [63:0] mant, scale, prod, n, ipart, fpart;
        logic [6:0]  txt[$];
        logic [6:0]  idig[$];
        int          e, p, sh, total, k;
        bit          neg;
        t_char       c;
        p = (num.precision > MAXPREC) ? MAXPREC : num.precision;
        expf = num.value_bits[30:23];
        neg = num.value_bits[31];
        if (expf >= 8'd158) begin
            expected_chars.push_back('{7'd0, 1'b1, 1'b1});
            return;
        end
        if (expf == 0) begin
            mant = {41'd0, num.value_bits[22:0]};
            e = -149;
        end else begin
            mant = {40'd0, 1'b1, num.value_bits[22:0]};
            e = int'(expf) - 150;
        end
        if (mant == 0) neg = 1'b0;
        scale = ten_to(p);
        prod = mant * scale;
        if (e >= 0) begin
            n = prod << e;
        end else begin
            sh = -e;
            n = (sh >= 60) ? 64'd0 : (prod + (64'd1 << (sh - 1))) >> sh;
        end
        ipart = n / scale;
        fpart = n % scale;
        do begin
            idig.push_front(CHAR_ZERO + 7'(ipart % 10));
            ipart = ipart / 10;
        end while (ipart != 0);
        total = int'(neg) + idig.size() + 1 + p;
        if (total > MAXLEN) begin
            expected_chars.push_back('{7'd0, 1'b1, 1'b1});
            return;
        end
        if (neg) txt.push_back(CHAR_MINUS);
        foreach (idig[i]) txt.push_back(idig[i]);
        txt.push_back(CHAR_POINT);
        for (int i = p - 1; i >= 0; i--) txt.push_back(CHAR_ZERO + 7'((fpart / ten_to(i)) % 10));
        for (k = 0; k < p && txt[$] == CHAR_ZERO; k++) void'(txt.pop_back());
        if (txt[$] == CHAR_POINT) void'(txt.pop_back());
        foreach (txt[i]) begin
            c.out_char = txt[i];
            c.last_char = (i == txt.size() - 1);
            c.overflow = 1'b0;
            expected_chars.push_back(c);
        end
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0:       v[30:23] = 8'($urandom_range(100, 157));
            1:       v[30:23] = 8'($urandom_range(110, 140));
            2:       v[30:23] = 8'($urandom_range(0, 4));
            3:       v[30:23] = 8'($urandom_range(150, 165));
            default: v[30:23] = 8'($urandom_range(120, 160));
        endcase
        if ($urandom_range(0, 9) == 0) v[22:0] = '0;
        return v;
    endfunction

    // Sender: bursts of items with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_axis_tvalid) begin
                    format_number(pending_numbers.pop_front());
                    number_count <= number_count + 1;
                end
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_numbers.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'd0, pending_numbers[0].precision,
                                     pending_numbers[0].value_bits};
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // Receiver: stalls following a rotating pattern, with stall-free stretches.
    logic [15:0] stall_pattern = 16'hffff;
    int          pattern_age = 0;
    always @(posedge i_clk) begin
        t_char got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[6:0], m_axis_tlast, m_axis_tuser};
                char_count <= char_count + 1;
                if (got.overflow) overflow_count <= overflow_count + 1;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected char, expected none, actual %p", $realtime, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch, expected %p, actual %p", $realtime, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pattern_age <= pattern_age + 1;
            if (pattern_age % 300 == 299)
                stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
            else
                stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            m_axis_tready <= stall_pattern[15];
        end
    end

    initial begin
        logic [31:0] directed[$];
        directed = '{32'h00000000, 32'h80000000, 32'h3f800000, 32'hbf800000,
                     32'h3f000000, 32'h3e800000, 32'hb3000000, 32'h4effffff,
                     32'h4f000000, 32'hcf000000, 32'h7f800000, 32'hff800000,
                     32'h7fc00001, 32'h00000001, 32'h807fffff, 32'h3dcccccd,
                     32'h40490fdb, 32'hc6407e00, 32'h4b7fffff, 32'h3fffffff,
                     32'hcefffffe, 32'h42c80000};
        foreach (directed[i]) pending_numbers.push_back('{directed[i], 3'(i)});
        pending_numbers.push_back('{32'h4effffff, 3'd7});
        pending_numbers.push_back('{32'hbf000000, 3'd0});
        pending_numbers.push_back('{32'h3f7fffff, 3'd7});
        for (int i = 0; i < 400; i++)
            pending_numbers.push_back('{random_value(), 3'($urandom_range(0, 7))});
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_chars.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d numbers and %0d characters, %0d overflow results.",
                 number_count, char_count, overflow_count);
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ftda_pkg.sv
rtl/core/ftda_datapath.sv
rtl/core/ftda_ctrl.sv
rtl/core/float_to_decimal_ascii_core.sv
rtl/core/ftda_checker.sv
dv/float_to_decimal_ascii_core_tb.sv
